/* hdl/fbpa_pkg.sv */
// shared types, constants and codes for the fixed block pool allocator
package fbpa_pkg;

   // field widths
   localparam int ADDR_W  = 33;
   localparam int BASE_W  = 32;
   localparam int ESIZE_W = 16;
   localparam int COUNT_W = 11;
   localparam int INDEX_W = 10;
   localparam int DATA_W  = 32;
   localparam int PADDR_W = 4;

   // built depth of the pool
   localparam int POOL_DEPTH_DEF = 1024;

   // register reset values
   localparam logic [BASE_W-1:0]  BASE_RESET  = 32'd0;
   localparam logic [ESIZE_W-1:0] ESIZE_RESET = 16'd64;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   // register indexes (paddr word address)
   localparam logic [1:0] REG_BASE  = 2'd0;
   localparam logic [1:0] REG_ESIZE = 2'd1;
   localparam logic [1:0] REG_COUNT = 2'd2;

   // request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_OUTSIDE   = 2'd2,
      STAT_NOT_ALLOC = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC_MUL,
      S_ALLOC_ADD,
      S_FREE_DIV,
      S_FREE_CHK
   } state_type;

   typedef struct packed {
      logic [BASE_W-1:0]  base_address;
      logic [ESIZE_W-1:0] element_size;
      logic [COUNT_W-1:0] pool_count;
   } cfg_type;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  block_address;
      logic [INDEX_W-1:0] block_index;
   } rsp_type;

endpackage

/* hdl/fbpa_div.sv */
// restoring divider, one quotient bit per cycle, for address to index conversion
module fbpa_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [fbpa_pkg::ADDR_W-1:0]       dividend,
   input  logic [fbpa_pkg::ESIZE_W-1:0]      divisor,
   output logic                              done,
   output logic [fbpa_pkg::ADDR_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(fbpa_pkg::ADDR_W);

   logic                              run_ff, run_in;
   logic                              done_ff, done_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic [fbpa_pkg::ESIZE_W-1:0]      rem_ff, rem_in;
   logic [fbpa_pkg::ADDR_W-1:0]       quo_ff, quo_in;
   logic [fbpa_pkg::ESIZE_W-1:0]      dvs_ff, dvs_in;
   logic [fbpa_pkg::ESIZE_W:0]        rem_sh;
   logic [fbpa_pkg::ESIZE_W:0]        diff;
   logic                              ge;

   // one shift and trial subtract
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[fbpa_pkg::ADDR_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      ge      = rem_sh >= {1'b0, dvs_ff};
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (run_ff) begin
         rem_in = ge ? diff[fbpa_pkg::ESIZE_W-1:0] : rem_sh[fbpa_pkg::ESIZE_W-1:0];
         quo_in = {quo_ff[fbpa_pkg::ADDR_W-2:0], ge};
         if (cnt_ff == CNT_W'(fbpa_pkg::ADDR_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hdl/fbpa_csr.sv */
// configuration registers behind the apb-style port
module fbpa_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fbpa_pkg::PADDR_W-1:0]      paddr,
   input  logic [fbpa_pkg::DATA_W-1:0]       pwdata,
   output logic [fbpa_pkg::DATA_W-1:0]       prdata,
   output logic                              pready,
   output fbpa_pkg::cfg_type                 cfg
);

   fbpa_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_beat;

   // register write on the access beat
   always_comb begin
      wr_beat = psel && penable && pwrite;
      cfg_in  = cfg_ff;
      if (wr_beat) begin
         case (paddr[3:2])
            fbpa_pkg::REG_BASE:  cfg_in.base_address = pwdata;
            fbpa_pkg::REG_ESIZE: cfg_in.element_size = pwdata[fbpa_pkg::ESIZE_W-1:0];
            fbpa_pkg::REG_COUNT: cfg_in.pool_count   = pwdata[fbpa_pkg::COUNT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address <= fbpa_pkg::BASE_RESET;
         cfg_ff.element_size <= fbpa_pkg::ESIZE_RESET;
         cfg_ff.pool_count   <= fbpa_pkg::COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (paddr[3:2])
         fbpa_pkg::REG_BASE:  prdata = cfg_ff.base_address;
         fbpa_pkg::REG_ESIZE: prdata = fbpa_pkg::DATA_W'(cfg_ff.element_size);
         fbpa_pkg::REG_COUNT: prdata = fbpa_pkg::DATA_W'(cfg_ff.pool_count);
         default: prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

/* hdl/fbpa_engine.sv */
// free list sequencer with the link / in-use memory and the index divider
module fbpa_engine #(
   parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  fbpa_pkg::req_type     req_data,
   input  fbpa_pkg::cfg_type     cfg,
   output logic                  rsp_strobe,
   output fbpa_pkg::rsp_type     rsp_data
);

   localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int LINK_W = $clog2(POOL_DEPTH + 1);

   // entry: in-use flag on top, link below
   logic [LINK_W:0]     mem [POOL_DEPTH];
   logic [LINK_W:0]     mem_rd_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_wa;
   logic [LINK_W:0]     mem_wd;
   logic [IDX_W-1:0]    mem_ra;

   fbpa_pkg::state_type state_ff, state_in;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [fbpa_pkg::BASE_W-1:0] prod_ff, prod_in;
   fbpa_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [LINK_W-1:0]            live;
   logic [fbpa_pkg::ESIZE_W-1:0] esize;
   logic [fbpa_pkg::ADDR_W-1:0]  offset;
   logic                         div_start;
   logic                         div_done;
   logic [fbpa_pkg::ADDR_W-1:0]  div_q;

   // effective count and stride
   assign live   = (32'(cfg.pool_count) > 32'(POOL_DEPTH)) ? LINK_W'(POOL_DEPTH)
                                                           : LINK_W'(cfg.pool_count);
   assign esize  = (cfg.element_size == '0) ? fbpa_pkg::ESIZE_W'(1) : cfg.element_size;
   assign offset = req_data.address - fbpa_pkg::ADDR_W'(cfg.base_address);

   fbpa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (offset),
      .divisor  (esize),
      .done     (div_done),
      .quotient (div_q)
   );

   // link and in-use store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      clr_in        = clr_ff;
      idx_in        = idx_ff;
      prod_in       = prod_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_wa        = idx_ff;
      mem_wd        = '0;
      mem_ra        = idx_ff;
      div_start     = 1'b0;
      busy          = 1'b1;
      case (state_ff)
         fbpa_pkg::S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = {1'b0, LINK_W'(clr_ff) + LINK_W'(1)};
            if (clr_ff == IDX_W'(POOL_DEPTH - 1)) begin
               state_in = fbpa_pkg::S_IDLE;
            end else begin
               clr_in = clr_ff + IDX_W'(1);
            end
         end
         fbpa_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_data.kind == fbpa_pkg::KIND_ALLOC) begin
                  if (head_ff >= live) begin
                     rsp_strobe_in = 1'b1;
                     rsp_data_in   = '{status: fbpa_pkg::STAT_EMPTY,
                                       block_address: '0, block_index: '0};
                  end else begin
                     mem_ra   = head_ff[IDX_W-1:0];
                     idx_in   = head_ff[IDX_W-1:0];
                     state_in = fbpa_pkg::S_ALLOC_MUL;
                  end
               end else begin
                  if (req_data.address < fbpa_pkg::ADDR_W'(cfg.base_address)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_data_in   = '{status: fbpa_pkg::STAT_OUTSIDE,
                                       block_address: '0, block_index: '0};
                  end else begin
                     div_start = 1'b1;
                     state_in  = fbpa_pkg::S_FREE_DIV;
                  end
               end
            end
         end
         fbpa_pkg::S_ALLOC_MUL: begin
            // pop: mark in use, head moves to the link
            mem_we   = 1'b1;
            mem_wa   = idx_ff;
            mem_wd   = {1'b1, mem_rd_ff[LINK_W-1:0]};
            head_in  = mem_rd_ff[LINK_W-1:0];
            prod_in  = fbpa_pkg::BASE_W'(idx_ff) * fbpa_pkg::BASE_W'(esize);
            state_in = fbpa_pkg::S_ALLOC_ADD;
         end
         fbpa_pkg::S_ALLOC_ADD: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = '{status: fbpa_pkg::STAT_DONE,
                              block_address: fbpa_pkg::ADDR_W'(cfg.base_address)
                                           + fbpa_pkg::ADDR_W'(prod_ff),
                              block_index: fbpa_pkg::INDEX_W'(idx_ff)};
            state_in      = fbpa_pkg::S_IDLE;
         end
         fbpa_pkg::S_FREE_DIV: begin
            if (div_done) begin
               if (div_q >= fbpa_pkg::ADDR_W'(live)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '{status: fbpa_pkg::STAT_OUTSIDE,
                                    block_address: '0, block_index: '0};
                  state_in      = fbpa_pkg::S_IDLE;
               end else begin
                  mem_ra   = div_q[IDX_W-1:0];
                  idx_in   = div_q[IDX_W-1:0];
                  state_in = fbpa_pkg::S_FREE_CHK;
               end
            end
         end
         fbpa_pkg::S_FREE_CHK: begin
            rsp_strobe_in = 1'b1;
            state_in      = fbpa_pkg::S_IDLE;
            if (!mem_rd_ff[LINK_W]) begin
               // double free or never allocated
               rsp_data_in = '{status: fbpa_pkg::STAT_NOT_ALLOC,
                               block_address: '0,
                               block_index: fbpa_pkg::INDEX_W'(idx_ff)};
            end else begin
               // push as the new head
               mem_we      = 1'b1;
               mem_wa      = idx_ff;
               mem_wd      = {1'b0, head_ff};
               head_in     = LINK_W'(idx_ff);
               rsp_data_in = '{status: fbpa_pkg::STAT_DONE,
                               block_address: '0,
                               block_index: fbpa_pkg::INDEX_W'(idx_ff)};
            end
         end
         default: begin
            state_in = fbpa_pkg::S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fbpa_pkg::S_CLEAR;
         head_ff       <= '0;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

/* hdl/fixed_block_pool_allocator_top.sv */
// top level of the fixed block pool allocator
//
//   channel   ports                                 beat taken when
//   request   start, busy, req_data                 start && !busy
//   result    rsp_strobe, rsp_data                  rsp_strobe (one cycle)
//   config    psel, penable, pwrite, paddr, ...     psel && penable && pwrite
//
// allocate goes from accept to result through a memory read, a multiply and an add, each registered
// free runs the 33-step restoring divider, then an in-use read, skipped if the index is past the pool
// an early reject (empty pool, address below base) gives its result the next cycle
// after reset a clearing pass over all POOL_DEPTH entries fills the link memory; busy is high
// one item is worked at a time; the result strobe cannot be held off
module fixed_block_pool_allocator_top #(
   parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  fbpa_pkg::req_type             req_data,
   output logic                          rsp_strobe,
   output fbpa_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [fbpa_pkg::PADDR_W-1:0]  paddr,
   input  logic [fbpa_pkg::DATA_W-1:0]   pwdata,
   output logic [fbpa_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   fbpa_pkg::cfg_type cfg;

   fbpa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fbpa_engine #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .cfg        (cfg),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

/* tb/fbpa_pool_checker.sv */
// result checker for the fixed block pool allocator: predicts every reply and compares it
module fbpa_pool_checker
   import fbpa_pkg::*;
#(
   parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  req_type             req_data,
   input  logic                rsp_strobe,
   input  rsp_type             rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic                pready,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output int                  fail_count,
   output int                  outstanding
);

   // shadow of the registers
   logic [BASE_W-1:0]  pool_base;
   logic [ESIZE_W-1:0] block_size;
   logic [COUNT_W-1:0] block_count;

   // shadow of the free list and the allocation flags
   logic [COUNT_W-1:0] link_mem [POOL_DEPTH];
   logic [COUNT_W-1:0] free_head;
   logic               in_use [POOL_DEPTH];

   // replies predicted but not yet seen on the result port
   rsp_type pending_replies [$];

   function automatic void restore_pool();
      pool_base   = BASE_RESET;
      block_size  = ESIZE_RESET;
      block_count = COUNT_RESET;
      for (int i = 0; i < POOL_DEPTH; i++) begin
         link_mem[i] = COUNT_W'(i + 1);
         in_use[i]   = 1'b0;
      end
      free_head = '0;
   endfunction

   // work out the reply to one request and advance the shadow pool
   function automatic rsp_type allocator_reply(req_type req);
      rsp_type            reply;
      logic [COUNT_W-1:0] live;
      logic [ADDR_W-1:0]  stride;
      logic [ADDR_W-1:0]  quot;
      logic [63:0]        sum;
      logic [COUNT_W-1:0] slot;
      reply        = '0;
      reply.status = STAT_DONE;
      live   = (block_count > POOL_DEPTH) ? COUNT_W'(POOL_DEPTH) : block_count;
      stride = (block_size == '0) ? ADDR_W'(1) : ADDR_W'(block_size);
      if (req.kind == KIND_ALLOC) begin
         if (free_head >= live) begin
            reply.status = STAT_EMPTY;
         end else begin
            slot = free_head;
            sum  = 64'(pool_base) + 64'(slot) * 64'(stride);
            reply.block_address = sum[ADDR_W-1:0];
            reply.block_index   = slot[INDEX_W-1:0];
            in_use[slot] = 1'b1;
            free_head    = link_mem[slot];
         end
      end else if (req.address < ADDR_W'(pool_base)) begin
         reply.status = STAT_OUTSIDE;
      end else begin
         // truncating divide: an address inside a block names that block
         quot = (req.address - ADDR_W'(pool_base)) / stride;
         if (quot >= ADDR_W'(live)) begin
            reply.status = STAT_OUTSIDE;
         end else begin
            slot = quot[COUNT_W-1:0];
            reply.block_index = slot[INDEX_W-1:0];
            if (!in_use[slot]) begin
               reply.status = STAT_NOT_ALLOC;
            end else begin
               in_use[slot]   = 1'b0;
               link_mem[slot] = free_head;
               free_head      = slot;
            end
         end
      end
      return reply;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      int      misses;
      misses = 0;
      if (reset) begin
         restore_pool();
         pending_replies.delete();
      end else begin
         // result beat against the oldest prediction
         if (rsp_strobe) begin
            if (pending_replies.size() == 0) begin
               $error("result beat with nothing outstanding: status %0d index %0d",
                      rsp_data.status, rsp_data.block_index);
               misses++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  misses++;
               end
               if (rsp_data.block_address !== want.block_address) begin
                  $error("block_address: expected %0h, actual %0h",
                         want.block_address, rsp_data.block_address);
                  misses++;
               end
               if (rsp_data.block_index !== want.block_index) begin
                  $error("block_index: expected %0d, actual %0d",
                         want.block_index, rsp_data.block_index);
                  misses++;
               end
            end
         end
         // register writes; indexes beyond the list are ignored
         if (psel && penable && pwrite && pready) begin
            case (paddr[PADDR_W-1:2])
               REG_BASE:  pool_base   = pwdata[BASE_W-1:0];
               REG_ESIZE: block_size  = pwdata[ESIZE_W-1:0];
               REG_COUNT: block_count = pwdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         // request beat
         if (start && !busy) pending_replies.push_back(allocator_reply(req_data));
      end
      fail_count  <= fail_count + misses;
      outstanding <= pending_replies.size();
   end

endmodule

/* tb/tb_fixed_block_pool_allocator_top.sv */
// testbench top for the fixed block pool allocator: stimulus, clock, reset and verdict
module tb_fixed_block_pool_allocator_top;
   import fbpa_pkg::*;

   // index past the register list, written to check it is ignored
   localparam logic [1:0] REG_SPARE = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_data = '0;
   logic                rsp_strobe;
   rsp_type             rsp_data;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   int fail_count;
   int outstanding;

   // current settings, used to aim free addresses at blocks
   logic [BASE_W-1:0]  cur_base  = BASE_RESET;
   logic [ESIZE_W-1:0] cur_esize = ESIZE_RESET;
   logic [COUNT_W-1:0] cur_count = COUNT_RESET;

   // blocks handed out and blocks recently given back
   logic [INDEX_W-1:0] held_blocks [$];
   logic [INDEX_W-1:0] released_blocks [$];
   logic               sent_kinds [$];

   int random_items = 0;
   int alloc_pct    = 50;
   int run_left     = 0;
   bit quiet        = 1'b0;

   fixed_block_pool_allocator_top DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   fbpa_pool_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // note granted blocks so that later frees can aim at them
   always @(posedge clock) begin
      if (rsp_strobe && sent_kinds.size() != 0) begin
         if (sent_kinds.pop_front() == KIND_ALLOC && rsp_data.status == STAT_DONE)
            held_blocks.push_back(rsp_data.block_index);
      end
      if (!reset && start && !busy) sent_kinds.push_back(req_data.kind);
   end

   function automatic logic [ADDR_W-1:0] pool_address(int idx, int ofs);
      logic [63:0] sum;
      logic [63:0] stride;
      stride = (cur_esize == '0) ? 64'd1 : 64'(cur_esize);
      sum    = 64'(cur_base) + 64'(idx) * stride + 64'(ofs);
      return sum[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] noise_address();
      return {1'($urandom_range(0, 1)), 32'($urandom())};
   endfunction

   // free address: mostly a held block, some double frees, stray blocks and noise
   function automatic logic [ADDR_W-1:0] free_address();
      int                 pick;
      int                 pos;
      int                 ofs;
      int                 stride;
      logic [INDEX_W-1:0] idx;
      pick   = $urandom_range(0, 99);
      stride = (cur_esize == '0) ? 1 : int'(cur_esize);
      ofs    = $urandom_range(0, 1) ? $urandom_range(0, stride - 1) : 0;
      if (pick < 55 && held_blocks.size() != 0) begin
         pos = $urandom_range(0, held_blocks.size() - 1);
         idx = held_blocks[pos];
         held_blocks.delete(pos);
         released_blocks.push_back(idx);
         if (released_blocks.size() > 16) void'(released_blocks.pop_front());
         return pool_address(idx, ofs);
      end
      if (pick < 65 && released_blocks.size() != 0)
         return pool_address(released_blocks[$urandom_range(0, released_blocks.size() - 1)],
                             ofs);
      if (pick < 80) return pool_address($urandom_range(0, 1024), ofs);
      if (pick < 87 && cur_base != '0) return ADDR_W'($urandom_range(0, cur_base - 1));
      return noise_address();
   endfunction

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 70) return quiet ? 0 : $urandom_range(0, 2);
      if (pick < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // one request beat; start stays high so a following beat can go straight on
   task automatic send_item(input logic kind, input logic [ADDR_W-1:0] address);
      req_data <= '{kind: kind, address: address};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // new settings, only once the allocator has gone quiet
   task automatic set_pool(input logic [BASE_W-1:0] base, input logic [ESIZE_W-1:0] esize,
                           input logic [COUNT_W-1:0] count);
      wait_idle();
      write_reg(REG_BASE, DATA_W'(base));
      write_reg(REG_ESIZE, DATA_W'(esize));
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom());
      write_reg(REG_COUNT, DATA_W'(count));
      cur_base  = base;
      cur_esize = esize;
      cur_count = count;
   endtask

   // one random phase: new settings, then runs of alloc-heavy, balanced and free-heavy beats
   task automatic random_phase();
      logic [BASE_W-1:0]  base;
      logic [ESIZE_W-1:0] esize;
      logic [COUNT_W-1:0] count;
      int                 pick;
      int                 len;
      int                 gap;
      pick = $urandom_range(0, 9);
      base = (pick < 3) ? '0 : (pick == 3) ? '1 : BASE_W'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 65)      esize = ESIZE_W'($urandom_range(1, 256));
      else if (pick < 80) esize = ESIZE_W'($urandom_range(257, 65535));
      else if (pick < 88) esize = '1;
      else                esize = '0;
      pick = $urandom_range(0, 99);
      if (pick < 60)      count = COUNT_W'($urandom_range(1, 24));
      else if (pick < 75) count = COUNT_W'($urandom_range(25, 1024));
      else if (pick < 82) count = COUNT_W'(POOL_DEPTH_DEF);
      else if (pick < 88) count = '0;
      else if (pick < 94) count = COUNT_W'($urandom_range(1025, 2047));
      else                count = COUNT_W'(1);
      set_pool(base, esize, count);
      quiet = ($urandom_range(0, 3) == 0);
      len   = $urandom_range(40, 160);
      for (int i = 0; i < len; i++) begin
         if (run_left == 0) begin
            pick      = $urandom_range(0, 2);
            alloc_pct = (pick == 0) ? 80 : (pick == 1) ? 50 : 20;
            run_left  = $urandom_range(5, 40);
         end
         run_left--;
         gap = pick_gap();
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         if ($urandom_range(0, 99) < alloc_pct) send_item(KIND_ALLOC, noise_address());
         else send_item(KIND_FREE, free_address());
         random_items++;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // clearing pass after reset
      do @(posedge clock); while (busy);

      // reset settings: in-order handout, reuse, mid-block address, double free, range
      send_item(KIND_FREE, pool_address(0, 0));
      send_item(KIND_ALLOC, '0);
      send_item(KIND_ALLOC, '1);
      send_item(KIND_ALLOC, noise_address());
      send_item(KIND_FREE, pool_address(1, 63));
      send_item(KIND_FREE, pool_address(1, 0));
      send_item(KIND_ALLOC, '0);
      send_item(KIND_FREE, pool_address(1024, 0));
      send_item(KIND_FREE, '1);
      send_item(KIND_FREE, pool_address(1023, 5));

      // top of the address range: below base, last byte of the pool and one past it
      set_pool('1, '1, COUNT_W'(POOL_DEPTH_DEF));
      send_item(KIND_FREE, '0);
      send_item(KIND_FREE, ADDR_W'(32'hFFFF_FFFE));
      send_item(KIND_ALLOC, '0);
      send_item(KIND_FREE, pool_address(1023, 65534));
      send_item(KIND_FREE, pool_address(1024, 0));

      // no blocks at all, zero element size
      set_pool(BASE_W'(256), '0, '0);
      send_item(KIND_ALLOC, '0);
      send_item(KIND_FREE, ADDR_W'(256));

      // count above the built depth
      set_pool('0, ESIZE_W'(1), '1);
      send_item(KIND_ALLOC, '0);

      // shrunk pool: links past the count end the list
      set_pool('0, ESIZE_W'(1), COUNT_W'(2));
      send_item(KIND_ALLOC, '0);
      send_item(KIND_FREE, ADDR_W'(0));
      send_item(KIND_ALLOC, '0);
      send_item(KIND_ALLOC, '0);

      while (random_items < 2000) random_phase();

      wait_idle();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

/* files.f */
hdl/fbpa_pkg.sv
hdl/fbpa_div.sv
hdl/fbpa_csr.sv
hdl/fbpa_engine.sv
hdl/fixed_block_pool_allocator_top.sv
tb/fbpa_pool_checker.sv
tb/tb_fixed_block_pool_allocator_top.sv
